// ----- hw/rtl/sci_pkg.sv -----
// ----------------------------------------------------------------------------
// sci_pkg
// Shared types and constants of the scaled colormap interpolator.
// ----------------------------------------------------------------------------
package sci_pkg;

  localparam int PW  = 16;
  localparam int CHW = 8;
  localparam int NCH = 4;
  localparam int VW  = 32;
  localparam int XW  = 34;
  localparam int DW  = 33;
  localparam int SW  = 51;
  localparam int DDW = PW + DW;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_LOG    = 2'd1;
  localparam logic [1:0] MODE_HYBRID = 2'd2;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_MAP  = 1'b1;

  localparam logic [1:0] CFG_SCALE_MODE  = 2'd0;
  localparam logic [1:0] CFG_RANGE_LOW   = 2'd1;
  localparam logic [1:0] CFG_RANGE_HIGH  = 2'd2;
  localparam logic [1:0] CFG_POINT_COUNT = 2'd3;

  localparam logic [30:0] LOG10_2_Q32 = 31'd1292913987;

  typedef logic [NCH-1:0][CHW-1:0] color_t;

  typedef struct packed {
    logic [PW-1:0] pos;
    color_t        col;
  } point_t;

  typedef struct packed {
    logic   valid;
    logic   hit;
    logic   hit_first;
    point_t prev;
    point_t a;
    point_t b;
    color_t first;
    color_t last;
  } wave_t;

endpackage

// ----- hw/rtl/sci_xform.sv -----
// ----------------------------------------------------------------------------
// sci_xform
// Scale transform of one value: linear, log10 or hybrid symmetric log.
// ----------------------------------------------------------------------------
module sci_xform import sci_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           mode,
  input  logic signed [VW-1:0] v,
  output logic                 done,
  output logic signed [XW-1:0] x
);

  localparam int LW  = 8 + FRAC_BITS;
  localparam int PRW = LW + 31;
  localparam int ITW = $clog2(FRAC_BITS + 1);
  localparam logic signed [VW-1:0] FX_ONE = VW'(64'd1 << FRAC_BITS);
  localparam logic signed [XW-1:0] LOG_FLOOR = XW'(-(64'sd64 <<< FRAC_BITS));
  localparam logic signed [7:0] EXP_BIAS = 8'(31 - FRAC_BITS);

  typedef enum logic [2:0] {XF_IDLE, XF_NORM, XF_SQ, XF_L2, XF_MUL, XF_FIN} xf_state_t;

  xf_state_t               state_r;
  logic                    done_r;
  logic signed [XW-1:0]    x_r;
  logic [VW-1:0]           w_r;
  logic [4:0]              s_r;
  logic [30:0]             m_r;
  logic [ITW-1:0]          it_r;
  logic [FRAC_BITS-1:0]    frac_r;
  logic                    neg_r;
  logic                    hyb_r;
  logic [LW-1:0]           mag_r;
  logic                    lneg_r;
  logic [LW-2:0]           r_r;

  logic [VW:0]             nv;
  logic [61:0]             sq;
  logic [31:0]             t;
  logic signed [7:0]       e;
  logic signed [LW-1:0]    l2;
  logic [PRW-1:0]          prod;
  logic signed [XW-1:0]    l10;
  logic signed [XW-1:0]    sum;

  always_comb begin
    nv   = -{v[VW-1], v};
    sq   = 62'(m_r) * 62'(m_r);
    t    = sq[61:30];
    e    = EXP_BIAS - $signed({3'b000, s_r});
    l2   = $signed({e, frac_r});
    prod = PRW'(mag_r) * PRW'(LOG10_2_Q32) + PRW'(64'h8000_0000);
    l10  = XW'(r_r);
    if (lneg_r) begin
      l10 = -l10;
    end
    sum = hyb_r ? l10 + XW'(FX_ONE) : l10;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= XF_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        XF_IDLE: begin
          if (start) begin
            s_r   <= '0;
            neg_r <= 1'b0;
            hyb_r <= 1'b0;
            w_r   <= v;
            case (mode)
              MODE_LOG: begin
                if (v <= 0) begin
                  x_r    <= LOG_FLOOR;
                  done_r <= 1'b1;
                end else begin
                  state_r <= XF_NORM;
                end
              end
              MODE_HYBRID: begin
                if (v > FX_ONE) begin
                  hyb_r   <= 1'b1;
                  state_r <= XF_NORM;
                end else if (v < -FX_ONE) begin
                  hyb_r   <= 1'b1;
                  neg_r   <= 1'b1;
                  w_r     <= nv[VW-1:0];
                  state_r <= XF_NORM;
                end else begin
                  x_r    <= {{(XW-VW){v[VW-1]}}, v};
                  done_r <= 1'b1;
                end
              end
              default: begin
                x_r    <= {{(XW-VW){v[VW-1]}}, v};
                done_r <= 1'b1;
              end
            endcase
          end
        end
        XF_NORM: begin
          if (w_r[31:24] == 8'd0) begin
            w_r <= {w_r[23:0], 8'd0};
            s_r <= s_r + 5'd8;
          end else if (!w_r[31]) begin
            w_r <= {w_r[30:0], 1'b0};
            s_r <= s_r + 5'd1;
          end else begin
            m_r     <= w_r[31:1];
            it_r    <= '0;
            frac_r  <= '0;
            state_r <= XF_SQ;
          end
        end
        XF_SQ: begin
          if (t[31]) begin
            m_r    <= t[31:1];
            frac_r <= {frac_r[FRAC_BITS-2:0], 1'b1};
          end else begin
            m_r    <= t[30:0];
            frac_r <= {frac_r[FRAC_BITS-2:0], 1'b0};
          end
          it_r <= it_r + 1'b1;
          if (it_r == ITW'(FRAC_BITS - 1)) begin
            state_r <= XF_L2;
          end
        end
        XF_L2: begin
          lneg_r  <= l2[LW-1];
          mag_r   <= l2[LW-1] ? LW'(-l2) : LW'(l2);
          state_r <= XF_MUL;
        end
        XF_MUL: begin
          r_r     <= prod[PRW-1:32];
          state_r <= XF_FIN;
        end
        XF_FIN: begin
          x_r     <= neg_r ? -sum : sum;
          done_r  <= 1'b1;
          state_r <= XF_IDLE;
        end
        default: begin
          state_r <= XF_IDLE;
        end
      endcase
    end
  end

  assign done = done_r;
  assign x    = x_r;

endmodule

// ----- hw/rtl/sci_cell.sv -----
// ----------------------------------------------------------------------------
// sci_cell
// One control point slot with its stage of the bracketing search chain.
// ----------------------------------------------------------------------------
module sci_cell import sci_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  point_t               wr_point,
  input  logic [DW-1:0]        den,
  input  logic signed [SW-1:0] scaled,
  input  logic [CW-1:0]        cnt,
  input  wave_t                wave_in,
  output wave_t                wave_out
);

  localparam logic [CW-1:0] ME = CW'(IDX);

  point_t        pt_r;
  wave_t         wave_r;
  wave_t         wave_nxt;
  logic [DDW-1:0] prod;
  logic          above;

  always_comb begin
    prod     = DDW'(pt_r.pos) * DDW'(den);
    above    = !($signed({2'b00, prod}) < scaled);
    wave_nxt = wave_in;
    wave_nxt.prev = pt_r;
    if (IDX == 0) begin
      wave_nxt.first = pt_r.col;
    end
    if (ME == cnt - 1'b1) begin
      wave_nxt.last = pt_r.col;
    end
    if (!wave_in.hit && (ME < cnt) && above) begin
      wave_nxt.hit       = 1'b1;
      wave_nxt.hit_first = 1'(IDX == 0);
      wave_nxt.a         = wave_in.prev;
      wave_nxt.b         = pt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pt_r <= wr_point;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r <= '0;
    end else begin
      wave_r <= wave_nxt;
    end
  end

  assign wave_out = wave_r;

endmodule

// ----- hw/rtl/sci_interp.sv -----
// ----------------------------------------------------------------------------
// sci_interp
// Channel interpolation between two points with a bit-serial rounding divide.
// ----------------------------------------------------------------------------
module sci_interp import sci_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  point_t               a,
  input  point_t               b,
  input  logic [DW-1:0]        den,
  input  logic signed [SW-1:0] scaled,
  output logic                 done,
  output color_t               col
);

  localparam int AW = DDW + 9;

  typedef enum logic [2:0] {IP_IDLE, IP_MUL, IP_SUB, IP_ACC, IP_DIV} ip_state_t;

  ip_state_t          state_r;
  logic               done_r;
  logic [DDW-1:0]     d_r;
  logic [DDW-1:0]     apd_r;
  logic [DDW-1:0]     n_r;
  logic [AW-1:0]      acc_r [NCH];
  logic [AW-1:0]      dsh_r;
  logic [2:0]         k_r;
  color_t             q_r;
  logic [PW-1:0]      dpos;
  logic signed [SW-1:0] ndiff;

  always_comb begin
    dpos  = b.pos - a.pos;
    ndiff = scaled - $signed({2'b00, apd_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IP_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        IP_IDLE: begin
          if (start) begin
            state_r <= IP_MUL;
          end
        end
        IP_MUL: begin
          d_r     <= DDW'(dpos) * DDW'(den);
          apd_r   <= DDW'(a.pos) * DDW'(den);
          state_r <= IP_SUB;
        end
        IP_SUB: begin
          n_r     <= ndiff[DDW-1:0];
          state_r <= IP_ACC;
        end
        IP_ACC: begin
          for (int c = 0; c < NCH; c++) begin
            acc_r[c] <= AW'(a.col[c]) * AW'(d_r - n_r) + AW'(b.col[c]) * AW'(n_r)
                      + AW'(d_r >> 1);
          end
          dsh_r   <= {d_r, 9'd0} >> 2;
          k_r     <= 3'd7;
          state_r <= IP_DIV;
        end
        IP_DIV: begin
          for (int c = 0; c < NCH; c++) begin
            if (acc_r[c] >= dsh_r) begin
              acc_r[c] <= acc_r[c] - dsh_r;
              q_r[c]   <= {q_r[c][CHW-2:0], 1'b1};
            end else begin
              q_r[c]   <= {q_r[c][CHW-2:0], 1'b0};
            end
          end
          dsh_r <= dsh_r >> 1;
          k_r   <= k_r - 3'd1;
          if (k_r == 3'd0) begin
            done_r  <= 1'b1;
            state_r <= IP_IDLE;
          end
        end
        default: begin
          state_r <= IP_IDLE;
        end
      endcase
    end
  end

  assign done = done_r;
  assign col  = q_r;

endmodule

// ----- hw/rtl/scaled_colormap_interpolator.sv -----
// ----------------------------------------------------------------------------
// scaled_colormap_interpolator
// Maps a Q16.16 sample to an RGBA color through a chain of control point cells.
// ----------------------------------------------------------------------------
// A load transfer writes its point into the addressed cell and gives no result.
// A map item runs the scale transform on the range low, the range high and the
// sample in turn, then the search through the cell chain and, when the sample
// falls between two points, the bit-serial divide.
// One item is in work at a time; the output register holds a result while the
// next item is taken. Reset clears control state and registers, not the points.
module scaled_colormap_interpolator import sci_pkg::*; #(
  parameter int NUM_POINTS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_req_type,
  input  logic signed [VW-1:0] in_sample_value,
  input  logic [3:0]           in_point_index,
  input  logic [PW-1:0]        in_point_position,
  input  logic [CHW-1:0]       in_point_red,
  input  logic [CHW-1:0]       in_point_green,
  input  logic [CHW-1:0]       in_point_blue,
  input  logic [CHW-1:0]       in_point_alpha,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CHW-1:0]       out_color_red,
  output logic [CHW-1:0]       out_color_green,
  output logic [CHW-1:0]       out_color_blue,
  output logic [CHW-1:0]       out_color_alpha,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [VW-1:0]        cfg_data
);

  localparam int CW = $clog2(NUM_POINTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_XF, ST_PREP, ST_SEARCH, ST_INTERP, ST_OUT
  } state_t;

  state_t               state_r;
  logic [1:0]           scale_mode_r;
  logic signed [VW-1:0] range_low_r;
  logic signed [VW-1:0] range_high_r;
  logic [4:0]           point_count_r;

  logic signed [VW-1:0] sample_r;
  logic [1:0]           xf_sel_r;
  logic                 xf_start_r;
  logic signed [VW-1:0] xf_v;
  logic                 xf_done;
  logic signed [XW-1:0] xf_x;
  logic signed [XW-1:0] x1_r;
  logic signed [XW-1:0] x2_r;
  logic signed [XW-1:0] xs_r;

  logic signed [XW:0]   num;
  logic signed [XW:0]   den;
  logic signed [XW:0]   num_adj;
  logic signed [XW:0]   den_adj;
  logic [DW-1:0]        den_r;
  logic signed [SW-1:0] scaled_r;
  logic                 den0_r;
  logic                 numpos_r;

  logic [CW-1:0]        cnt_eff;
  logic                 in_acc;
  point_t               wr_point;
  logic                 wave_go_r;
  wave_t                waves [NUM_POINTS+1];
  wave_t                wave_end;

  logic                 ip_start_r;
  point_t               ip_a_r;
  point_t               ip_b_r;
  logic                 ip_done;
  color_t               ip_col;

  color_t               res_col_r;
  color_t               out_col_r;
  logic                 out_valid_r;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign wr_point = '{pos: in_point_position,
                      col: {in_point_alpha, in_point_blue, in_point_green, in_point_red}};

  always_comb begin
    if (point_count_r < 5'd2) begin
      cnt_eff = CW'(2);
    end else if (int'(point_count_r) > NUM_POINTS) begin
      cnt_eff = CW'(NUM_POINTS);
    end else begin
      cnt_eff = CW'(point_count_r);
    end
  end

  always_comb begin
    case (xf_sel_r)
      2'd0:    xf_v = range_low_r;
      2'd1:    xf_v = range_high_r;
      default: xf_v = sample_r;
    endcase
  end

  always_comb begin
    num     = {xs_r[XW-1], xs_r} - {x1_r[XW-1], x1_r};
    den     = {x2_r[XW-1], x2_r} - {x1_r[XW-1], x1_r};
    num_adj = den[XW] ? -num : num;
    den_adj = den[XW] ? -den : den;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mode_r  <= MODE_LINEAR;
      range_low_r   <= '0;
      range_high_r  <= VW'(32'h0001_0000);
      point_count_r <= 5'd2;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SCALE_MODE:  scale_mode_r  <= cfg_data[1:0];
        CFG_RANGE_LOW:   range_low_r   <= cfg_data;
        CFG_RANGE_HIGH:  range_high_r  <= cfg_data;
        CFG_POINT_COUNT: point_count_r <= cfg_data[4:0];
        default:         scale_mode_r  <= scale_mode_r;
      endcase
    end
  end

  sci_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
    .clk   (clk),
    .rst_n (rst_n),
    .start (xf_start_r),
    .mode  (scale_mode_r),
    .v     (xf_v),
    .done  (xf_done),
    .x     (xf_x)
  );

  always_comb begin
    waves[0]       = '0;
    waves[0].valid = wave_go_r;
  end

  for (genvar i = 0; i < NUM_POINTS; i++) begin : g_cell
    sci_cell #(.IDX(i), .CW(CW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (in_acc && (in_req_type == REQ_LOAD) && (int'(in_point_index) == i)),
      .wr_point (wr_point),
      .den      (den_r),
      .scaled   (scaled_r),
      .cnt      (cnt_eff),
      .wave_in  (waves[i]),
      .wave_out (waves[i+1])
    );
  end

  assign wave_end = waves[NUM_POINTS];

  sci_interp u_interp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ip_start_r),
    .a      (ip_a_r),
    .b      (ip_b_r),
    .den    (den_r),
    .scaled (scaled_r),
    .done   (ip_done),
    .col    (ip_col)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      xf_start_r  <= 1'b0;
      xf_sel_r    <= 2'd0;
      wave_go_r   <= 1'b0;
      ip_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      xf_start_r <= 1'b0;
      wave_go_r  <= 1'b0;
      ip_start_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_req_type == REQ_MAP)) begin
            sample_r   <= in_sample_value;
            xf_sel_r   <= 2'd0;
            xf_start_r <= 1'b1;
            state_r    <= ST_XF;
          end
        end
        ST_XF: begin
          if (xf_done) begin
            case (xf_sel_r)
              2'd0:    x1_r <= xf_x;
              2'd1:    x2_r <= xf_x;
              default: xs_r <= xf_x;
            endcase
            if (xf_sel_r == 2'd2) begin
              state_r <= ST_PREP;
            end else begin
              xf_sel_r   <= xf_sel_r + 2'd1;
              xf_start_r <= 1'b1;
            end
          end
        end
        ST_PREP: begin
          den0_r    <= (den == '0);
          numpos_r  <= !num[XW] && (num != '0);
          den_r     <= den_adj[DW-1:0];
          scaled_r  <= $signed({num_adj, 16'd0});
          wave_go_r <= 1'b1;
          state_r   <= ST_SEARCH;
        end
        ST_SEARCH: begin
          if (wave_end.valid) begin
            if (den0_r) begin
              res_col_r <= numpos_r ? wave_end.last : wave_end.first;
              state_r   <= ST_OUT;
            end else if (!wave_end.hit) begin
              res_col_r <= wave_end.last;
              state_r   <= ST_OUT;
            end else if (wave_end.hit_first) begin
              res_col_r <= wave_end.b.col;
              state_r   <= ST_OUT;
            end else begin
              ip_a_r     <= wave_end.a;
              ip_b_r     <= wave_end.b;
              ip_start_r <= 1'b1;
              state_r    <= ST_INTERP;
            end
          end
        end
        ST_INTERP: begin
          if (ip_done) begin
            res_col_r <= ip_col;
            state_r   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_col_r   <= res_col_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_color_red   = out_col_r[0];
  assign out_color_green = out_col_r[1];
  assign out_color_blue  = out_col_r[2];
  assign out_color_alpha = out_col_r[3];

  ap_wave_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    wave_end.valid |-> state_r == ST_SEARCH)
    else $error("Search wave left the chain outside the search state.");

  ap_xf_in_xf: assert property (@(posedge clk) disable iff (!rst_n)
    xf_done |-> state_r == ST_XF)
    else $error("Transform finished outside the transform state.");

  ap_ip_in_interp: assert property (@(posedge clk) disable iff (!rst_n)
    ip_done |-> state_r == ST_INTERP)
    else $error("Interpolation finished outside the interpolation state.");

  ap_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) && out_valid_r && out_stall |=> state_r == ST_OUT)
    else $error("Result overwrote a transfer still waiting at the output.");

endmodule

// ----- test/scaled_colormap_interpolator_test.sv -----
// ----------------------------------------------------------------------------
// Scaled colormap interpolator testbench
// Loads control point tables and maps samples under linear, log and hybrid
// scaling with many range and point count settings. Every color is compared
// channel by channel with an independent fixed-point prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import sci_pkg::*;

class colormap_scoreboard;
  localparam int FB = 16;
  localparam int NP = 16;

  bit [1:0]  mode;
  bit [31:0] lo;
  bit [31:0] hi;
  bit [4:0]  cnt_reg;
  bit [15:0] pos [NP];
  bit [7:0]  chan [NP][4];
  bit [31:0] pending_colors [$];
  int        errors;
  int        maps;
  int        loads;

  function new();
    mode    = MODE_LINEAR;
    lo      = 0;
    hi      = 32'h0001_0000;
    cnt_reg = 2;
  endfunction

  function void set_reg(bit [1:0] idx, bit [31:0] data);
    case (idx)
      CFG_SCALE_MODE:  mode = data[1:0];
      CFG_RANGE_LOW:   lo = data;
      CFG_RANGE_HIGH:  hi = data;
      CFG_POINT_COUNT: cnt_reg = data[4:0];
    endcase
  endfunction

  function longint log2_fx(longint unsigned u);
    int p;
    longint unsigned m;
    longint frac;
    p = 63;
    frac = 0;
    while (p > 0 && !u[p]) p--;
    if (p <= 30) m = u << (30 - p);
    else m = u >> (p - 30);
    for (int i = 0; i < FB; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return longint'(p - FB) * (longint'(1) << FB) + frac;
  endfunction

  function longint log10_fx(longint unsigned u);
    longint l2;
    longint unsigned mag;
    longint unsigned r;
    l2 = log2_fx(u);
    mag = (l2 < 0) ? -l2 : l2;
    r = (mag * longint'(LOG10_2_Q32) + 64'h8000_0000) >> 32;
    return (l2 < 0) ? -longint'(r) : longint'(r);
  endfunction

  function longint scale_value(bit [31:0] raw);
    longint v;
    longint one;
    v = longint'($signed(raw));
    one = longint'(1) << FB;
    if (mode == MODE_LOG) begin
      if (v <= 0) return -(longint'(64) << FB);
      return log10_fx(v);
    end
    if (mode == MODE_HYBRID) begin
      if (v > one) return one + log10_fx(v);
      if (v < -one) return -one - log10_fx(-v);
    end
    return v;
  endfunction

  function bit [31:0] map_color(bit [31:0] sample);
    int cnt;
    int idx;
    int k;
    longint x1, x2, x, num, den, scaled, pa, pb, pi;
    longint unsigned n, d, acc;
    bit [31:0] res;
    cnt = (cnt_reg < 2) ? 2 : (cnt_reg > NP) ? NP : cnt_reg;
    x1 = scale_value(lo);
    x2 = scale_value(hi);
    x = scale_value(sample);
    num = x - x1;
    den = x2 - x1;
    scaled = 0;
    if (den == 0) begin
      idx = (num > 0) ? cnt : 0;
    end else begin
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      scaled = num * 65536;
      idx = cnt;
      for (int i = 0; i < cnt; i++) begin
        pi = pos[i];
        if (!(pi * den < scaled)) begin
          idx = i;
          break;
        end
      end
    end
    if (idx == 0 || idx >= cnt) begin
      k = (idx == 0) ? 0 : cnt - 1;
      for (int c = 0; c < 4; c++) res[31 - 8 * c -: 8] = chan[k][c];
    end else begin
      pa = pos[idx - 1];
      pb = pos[idx];
      n = scaled - pa * den;
      d = (pb - pa) * den;
      for (int c = 0; c < 4; c++) begin
        acc = longint'(chan[idx - 1][c]) * (d - n) + longint'(chan[idx][c]) * n + d / 2;
        res[31 - 8 * c -: 8] = acc / d;
      end
    end
    return res;
  endfunction

  function void note_input(bit req, bit [31:0] sample, bit [3:0] slot, bit [15:0] p,
                           bit [31:0] rgba);
    if (req == REQ_LOAD) begin
      loads++;
      pos[slot] = p;
      for (int c = 0; c < 4; c++) chan[slot][c] = rgba[31 - 8 * c -: 8];
    end else begin
      maps++;
      pending_colors.push_back(map_color(sample));
    end
  endfunction

  function void check_color(bit [31:0] got);
    bit [31:0] exp_color;
    string names [4];
    names = '{"red", "green", "blue", "alpha"};
    if (pending_colors.size() == 0) begin
      $display("%0t: unexpected color %h", $time, got);
      errors++;
      return;
    end
    exp_color = pending_colors.pop_front();
    for (int c = 0; c < 4; c++) begin
      if (exp_color[31 - 8 * c -: 8] !== got[31 - 8 * c -: 8]) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, names[c],
                 exp_color[31 - 8 * c -: 8], got[31 - 8 * c -: 8]);
        errors++;
      end
    end
  endfunction
endclass

module scaled_colormap_interpolator_test;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 160;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic signed [31:0] in_sample_value;
  logic [3:0]  in_point_index;
  logic [15:0] in_point_position;
  logic [7:0]  in_point_red;
  logic [7:0]  in_point_green;
  logic [7:0]  in_point_blue;
  logic [7:0]  in_point_alpha;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_color_red;
  logic [7:0]  out_color_green;
  logic [7:0]  out_color_blue;
  logic [7:0]  out_color_alpha;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  colormap_scoreboard colors = new();
  int tx_idle_pct;
  int rx_idle_pct;
  int quiet_cycles;
  int cfg_writes;

  scaled_colormap_interpolator i_dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < rx_idle_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      colors.check_color({out_color_red, out_color_green, out_color_blue, out_color_alpha});
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(bit req, bit [31:0] sample, bit [3:0] slot, bit [15:0] p,
                           bit [31:0] rgba);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      while ($urandom_range(99) < tx_idle_pct) @(negedge clk);
      @(negedge clk);
    end
    in_req_type = req;
    in_sample_value = sample;
    in_point_index = slot;
    in_point_position = p;
    {in_point_red, in_point_green, in_point_blue, in_point_alpha} = rgba;
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    colors.note_input(req, sample, slot, p, rgba);
    @(negedge clk);
  endtask

  task automatic map_sample(bit [31:0] sample);
    send_item(REQ_MAP, sample, $urandom, $urandom, $urandom);
  endtask

  task automatic load_point(bit [3:0] slot, bit [15:0] p, bit [31:0] rgba);
    send_item(REQ_LOAD, $urandom, slot, p, rgba);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (colors.pending_colors.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [31:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    colors.set_reg(idx, data);
    cfg_writes++;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic configure(bit [1:0] m, bit [31:0] low, bit [31:0] high, bit [4:0] cnt);
    wait_idle();
    write_reg(CFG_SCALE_MODE, m);
    write_reg(CFG_RANGE_LOW, low);
    write_reg(CFG_RANGE_HIGH, high);
    write_reg(CFG_POINT_COUNT, cnt);
  endtask

  task automatic load_sorted_table();
    int p;
    p = 0;
    for (int i = 0; i < 16; i++) begin
      load_point(i, p, $urandom);
      p = p + $urandom_range(0, 65535 / 15);
      if (p > 65535) p = 65535;
    end
  endtask

  initial begin
    bit [31:0] low, high, s;
    longint span;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_LOAD;
    in_sample_value = '0;
    in_point_index = '0;
    in_point_position = '0;
    {in_point_red, in_point_green, in_point_blue, in_point_alpha} = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_SCALE_MODE;
    cfg_data = '0;
    quiet_cycles = 0;
    tx_idle_pct = 18;
    rx_idle_pct = 83;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < 16; i++)
      load_point(i, (i == 15) ? 16'hFFFF : i * 4369, (i % 2) ? 32'hFFFF_FFFF : 32'h0);
    map_sample(32'h0);
    map_sample(32'h0001_0000);
    map_sample(32'h0000_8000);
    map_sample(32'hFFFF_FFFF);
    map_sample(32'h8000_0000);
    map_sample(32'h7FFF_FFFF);
    configure(MODE_LINEAR, 0, 32'h0001_0000, 0);
    map_sample(32'h0000_C000);
    configure(2'd3, 0, 32'h0001_0000, 31);
    map_sample(32'h0000_7777);
    configure(MODE_LINEAR, 32'h0001_0000, 32'h0001_0000, 16);
    map_sample(32'h0001_0000);
    map_sample(32'h0001_0001);
    configure(MODE_LINEAR, 32'h0001_0000, 32'h0, 16);
    map_sample(32'h0000_4000);
    configure(MODE_LOG, 32'h1, 32'h7FFF_FFFF, 16);
    map_sample(32'h0);
    map_sample(32'hFFFF_FFFB);
    map_sample(32'h1);
    map_sample(32'h0001_0000);
    configure(MODE_HYBRID, 32'h8000_0000, 32'h7FFF_FFFF, 16);
    map_sample(32'hFFFE_FFFF);
    map_sample(32'hFFFF_0000);
    map_sample(32'h0001_0001);
    map_sample(32'h0);

    for (int phase = 0; phase < 12; phase++) begin
      if (phase < 4) begin
        tx_idle_pct = 18;
        rx_idle_pct = 83;
      end else if (phase < 8) begin
        tx_idle_pct = 83;
        rx_idle_pct = 18;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case ($urandom_range(3))
        0: begin
          low = $urandom;
          high = $urandom;
        end
        1: begin
          low = $urandom_range(0, 32'h0004_0000);
          high = low + $urandom_range(1, 32'h0100_0000);
        end
        2: begin
          low = -$urandom_range(0, 32'h0100_0000);
          high = $urandom_range(0, 32'h0100_0000);
        end
        default: begin
          low = $urandom;
          high = low;
        end
      endcase
      configure($urandom_range(3), low, high, $urandom_range(31));
      if ($urandom_range(1)) load_sorted_table();
      span = longint'($signed(high)) - longint'($signed(low));
      for (int i = 0; i < 30; i++) begin
        case ($urandom_range(9))
          0: load_point($urandom, $urandom, $urandom);
          1, 2: map_sample($urandom);
          3: map_sample($urandom_range(0, 32'h0003_0000) - 32'h0001_8000);
          default: begin
            s = longint'($signed(low)) + span * $urandom_range(0, 1200) / 1000;
            map_sample(s);
          end
        endcase
      end
    end
    wait_idle();

    $display("Covered %0d point loads, %0d mapped colors and %0d register writes,",
             colors.loads, colors.maps, cfg_writes);
    $display("over all scale modes, clamped point counts and empty or reversed ranges.");
    if (colors.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
